### sv/u16u8_pkg.sv
// Package: job record, sizes and the UTF-8 byte encoder shared by the transcoder.
package u16u8_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic [5:0] HighSurPrefix = 6'b110110;
  localparam logic [5:0] LowSurPrefix  = 6'b110111;

  localparam logic [2:0] LenNone  = 3'd0;
  localparam logic [2:0] LenOne   = 3'd1;
  localparam logic [2:0] LenTwo   = 3'd2;
  localparam logic [2:0] LenThree = 3'd3;
  localparam logic [2:0] LenFour  = 3'd4;

  // One queued job: optional flush of a held high surrogate, then the main code point, if any.
  typedef struct packed {
    logic        pre_valid;
    logic [9:0]  pre_bits;
    logic [2:0]  main_len;
    logic [20:0] main_cp;
    logic        last;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_status_t;

  function automatic logic [2:0] bmp_len(logic [15:0] u);
    logic [2:0] l;
    if (u < 16'h0080) begin
      l = LenOne;
    end else if (u < 16'h0800) begin
      l = LenTwo;
    end else begin
      l = LenThree;
    end
    return l;
  endfunction

  function automatic logic [7:0] utf8_byte(logic [20:0] cp, logic [2:0] len, logic [1:0] idx);
    logic [1:0] rem;
    logic [5:0] six;
    logic [7:0] b;
    rem = len[1:0] - 2'd1 - idx;
    case (rem)
      2'd0: six = cp[5:0];
      2'd1: six = cp[11:6];
      2'd2: six = cp[17:12];
      default: six = {3'b000, cp[20:18]};
    endcase
    if (idx == 2'd0) begin
      case (len)
        LenOne:   b = {1'b0, cp[6:0]};
        LenTwo:   b = {3'b110, cp[10:6]};
        LenThree: b = {4'b1110, cp[15:12]};
        default:  b = {5'b11110, cp[20:18]};
      endcase
    end else begin
      b = {2'b10, six};
    end
    return b;
  endfunction

endpackage

### sv/u16u8_fifo.sv
// Small register queue between the classifier and the byte sequencer.
module u16u8_fifo
  import u16u8_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth,
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  input  logic             pop_i,
  output logic [Width-1:0] head_o,
  output fifo_status_t     status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign status_o.empty = (cnt_q == '0);
  assign status_o.full  = (cnt_q == CntW'(Depth));
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### sv/u16u8_front.sv
// Front end: accepts code units, tracks a held high surrogate, builds jobs.
module u16u8_front
  import u16u8_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  logic [15:0]  code_unit_i,
  input  logic         last_unit_i,
  input  fifo_status_t fifo_status_i,
  output logic         push_o,
  output job_t         job_o
);

  logic       held_valid_q, held_valid_d;
  logic [9:0] held_bits_q, held_bits_d;
  logic       accept, is_high, is_low;

  assign in_stall_o = fifo_status_i.full;
  assign accept     = in_valid_i && !fifo_status_i.full;
  assign is_high    = (code_unit_i[15:10] == HighSurPrefix);
  assign is_low     = (code_unit_i[15:10] == LowSurPrefix);

  always_comb begin
    held_valid_d   = held_valid_q;
    held_bits_d    = held_bits_q;
    push_o         = 1'b0;
    job_o.pre_valid = 1'b0;
    job_o.pre_bits  = held_bits_q;
    job_o.main_len  = LenNone;
    job_o.main_cp   = {5'b0, code_unit_i};
    job_o.last      = last_unit_i;
    if (held_valid_q && is_low) begin
      job_o.main_len = LenFour;
      job_o.main_cp  = 21'h10000 + {1'b0, held_bits_q, code_unit_i[9:0]};
      push_o         = accept;
      if (accept) begin
        held_valid_d = 1'b0;
        held_bits_d  = '0;
      end
    end else begin
      job_o.pre_valid = held_valid_q;
      if (is_high && !last_unit_i) begin
        push_o = accept && held_valid_q;
        if (accept) begin
          held_valid_d = 1'b1;
          held_bits_d  = code_unit_i[9:0];
        end
      end else begin
        job_o.main_len = bmp_len(code_unit_i);
        push_o         = accept;
        if (accept) begin
          held_valid_d = 1'b0;
          held_bits_d  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q <= 1'b0;
      held_bits_q  <= '0;
    end else begin
      held_valid_q <= held_valid_d;
      held_bits_q  <= held_bits_d;
    end
  end

endmodule

### sv/u16u8_back.sv
// Back end: walks the head job one byte per cycle, while the output is not stalled, into the output register.
module u16u8_back
  import u16u8_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  job_t         job_i,
  input  fifo_status_t fifo_status_i,
  output logic         pop_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic [7:0]   out_byte_o,
  output logic         run_last_o,
  output logic         string_end_o
);

  logic [2:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  logic       run_last_q, string_end_q;
  logic [2:0] total, main_idx;
  logic [7:0] cur_byte;
  logic       load, final_byte;

  assign total      = job_i.pre_valid ? job_i.main_len + LenThree : job_i.main_len;
  assign main_idx   = job_i.pre_valid ? idx_q - LenThree : idx_q;
  assign final_byte = (idx_q == total - 3'd1);
  assign load       = !fifo_status_i.empty && (!out_valid_q || !out_stall_i);
  assign pop_o      = load && final_byte;

  always_comb begin
    if (job_i.pre_valid && (idx_q < LenThree)) begin
      cur_byte = utf8_byte({5'b0, HighSurPrefix, job_i.pre_bits}, LenThree, idx_q[1:0]);
    end else begin
      cur_byte = utf8_byte(job_i.main_cp, job_i.main_len, main_idx[1:0]);
    end
  end

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (load) begin
      out_valid_d = 1'b1;
      idx_d       = final_byte ? 3'd0 : idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q   <= cur_byte;
      run_last_q   <= final_byte;
      string_end_q <= final_byte && job_i.last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign run_last_o   = run_last_q;
  assign string_end_o = string_end_q;

endmodule

### sv/utf16be_to_utf8_transcoder.sv
// Top level: UTF-16 code units in, UTF-8 bytes out.
//
// Input channel: one 16-bit code unit per transaction (first byte in the upper
// half) with last_unit_i marking the final unit of a string. Output channel:
// one UTF-8 byte per transaction; run_last_o flags the final byte caused by an
// input unit and string_end_o the final byte of the string.
// A high surrogate that is not last is held and produces nothing until the
// next unit arrives; a following low surrogate gives four bytes, anything else
// flushes the held unit as three bytes before the new unit is handled.
// The first byte of a unit passes through the job queue and then the output
// register. The byte sequencer emits one byte per cycle while out_stall_i is
// low; a job gives 1 to 6 bytes (typically 1 to 3), and the front end takes a
// unit every cycle while the job queue has room.
// Reset clears the held surrogate, the job queue and the output valid flag.
// When the receiver stalls, the output byte holds, the queue fills and then
// in_stall_o rises to hold off further units.
module utf16be_to_utf8_transcoder
  import u16u8_pkg::*;
#(
  parameter int unsigned QDepth = QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] code_unit_i,
  input  logic        last_unit_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        run_last_o,
  output logic        string_end_o
);

  fifo_status_t fifo_status;
  job_t         push_job, head_job;
  logic         push, pop;

  u16u8_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .code_unit_i  (code_unit_i),
    .last_unit_i  (last_unit_i),
    .fifo_status_i(fifo_status),
    .push_o       (push),
    .job_o        (push_job)
  );

  u16u8_fifo #(
    .Depth(QDepth),
    .Width($bits(job_t))
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_job),
    .pop_i      (pop),
    .head_o     (head_job),
    .status_o   (fifo_status)
  );

  u16u8_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_i        (head_job),
    .fifo_status_i(fifo_status),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .run_last_o   (run_last_o),
    .string_end_o (string_end_o)
  );

endmodule

### sv/u16u8_checker.sv
// Port-level checker for the transcoder, bound to the top level.
module u16u8_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  out_byte_o,
  input logic        run_last_o,
  input logic        string_end_o
);

  logic boundary_q;

  // Set when the next output byte must start a new sequence.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      boundary_q <= 1'b1;
    end else if (out_valid_o && !out_stall_i) begin
      boundary_q <= run_last_o;
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(run_last_o) && $stable(string_end_o))
    else $error("output changed while stalled");

  a_end_on_run_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && string_end_o |-> run_last_o)
    else $error("string end without run end");

  a_ascii_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_byte_o[7] |-> run_last_o)
    else $error("single-byte sequence not marked as run end");

  a_run_starts_lead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && boundary_q |-> out_byte_o[7:6] != 2'b10)
    else $error("run starts with a continuation byte");

endmodule

bind utf16be_to_utf8_transcoder u16u8_checker u_u16u8_checker (.*);
